>>> src/imf_pkg.sv
// Shared constants, codes and types of the Ising spin-flip block.
`timescale 1ns / 1ps

package imf_pkg;

	// Field widths
	localparam int SITE_W     = 12;
	localparam int DRAW_W     = 12;
	localparam int THR_W      = 12;
	localparam int THR_N      = 5;
	localparam int TABLE_W    = THR_W * THR_N;
	localparam int COUPLING_W = 5;
	localparam int FIELD_W    = 5;
	localparam int DE_OUT_W   = 8;
	localparam int ENERGY_W   = 23;
	localparam int MAGNET_W   = 14;

	// Internal widths
	localparam int ALU_W   = 24;
	localparam int ACC_W   = 9;
	localparam int DE_W    = 10;
	localparam int STEP_W  = 4;
	localparam int PLUS_W  = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = TABLE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_J  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_H     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_PLUS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MINUS = 2'd3;

	// Request codes and spin encoding
	localparam logic REQ_FLIP   = 1'b0;
	localparam logic REQ_SET    = 1'b1;
	localparam logic SPIN_PLUS  = 1'b0;
	localparam logic SPIN_MINUS = 1'b1;

	localparam int LATTICE_SIDE_DEF = 64;

	// One operation of the shared adder
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_op_t;

endpackage

>>> src/imf_ifc.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface imf_req_if import imf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SITE_W-1:0] site_index;
	logic [DRAW_W-1:0] random_draw;
	logic              spin_value;

	modport source (output valid, output req_type, output site_index,
		output random_draw, output spin_value, input ready);
	modport sink (input valid, input req_type, input site_index,
		input random_draw, input spin_value, output ready);
endinterface

interface imf_rsp_if import imf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       flipped;
	logic                       spin_now;
	logic signed [DE_OUT_W-1:0] energy_change;
	logic signed [ENERGY_W-1:0] energy_total;
	logic signed [MAGNET_W-1:0] magnetization;

	modport source (output valid, output flipped, output spin_now,
		output energy_change, output energy_total, output magnetization, input ready);
	modport sink (input valid, input flipped, input spin_now,
		input energy_change, input energy_total, input magnetization, output ready);
endinterface

>>> src/imf_alu.sv
// Shared add/subtract unit with sign flag.
`timescale 1ns / 1ps

module imf_alu import imf_pkg::*; (
	input  alu_op_t          op,
	output logic [ALU_W-1:0] res,
	output logic             neg
);

	always_comb begin
		res = op.a + (op.sub ? ~op.b : op.b) + ALU_W'(op.sub);
		neg = res[ALU_W-1];
	end

endmodule

>>> src/imf_lattice.sv
// One-bit spin memory with one registered read port and one write port.
`timescale 1ns / 1ps

module imf_lattice import imf_pkg::*; #(
	parameter int LATTICE_SIDE = LATTICE_SIDE_DEF
) (
	input  logic                                       clk,
	input  logic                                       rd_en,
	input  logic [$clog2(LATTICE_SIDE*LATTICE_SIDE)-1:0] rd_addr,
	output logic                                       rd_data,
	input  logic                                       wr_en,
	input  logic [$clog2(LATTICE_SIDE*LATTICE_SIDE)-1:0] wr_addr,
	input  logic                                       wr_data
);

	localparam int DEPTH = LATTICE_SIDE * LATTICE_SIDE;

	logic mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/ising_metropolis_flip.sv
// Metropolis spin-flip engine on a square Ising lattice of one-bit spins.
`timescale 1ns / 1ps

// The block holds LATTICE_SIDE x LATTICE_SIDE spins (all +1 after reset) and
// serves one request at a time: a Metropolis flip attempt or a forced set of
// one site. Neighbors are the sites at linear index +-1 and +-LATTICE_SIDE,
// wrapping over the site count; a site index beyond the lattice is reduced
// modulo the site count. After reset the lattice is swept clear, one site per
// cycle; requests wait during that pass, configuration writes are taken. All
// work goes through one shared 24-bit adder and a spin memory with one read
// port and one write port: an item reads its site, then addresses and adds
// each of the four neighbors in turn, scales the local field, decides, updates
// the running sums on a flip, and loads the output register once it is free;
// the next item is accepted when the sequencer is back in idle. Lattices under
// 4096 sites add compare-subtract steps to reduce the site index. The result
// sits in an output register, so the next item can be accepted while it
// waits to be taken.
// Configuration (J, h and the two threshold tables) may be written only
// while no item is in flight.

module ising_metropolis_flip import imf_pkg::*; #(
	parameter int LATTICE_SIDE = LATTICE_SIDE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	imf_req_if.sink               req,
	imf_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
	localparam int AW         = $clog2(SITE_COUNT);
	localparam int RW         = (AW > SITE_W) ? AW : SITE_W;
	// compare-subtract steps needed to bring a 12-bit index below SITE_COUNT
	localparam int MOD_STEPS  = (SITE_COUNT > (1 << SITE_W) - 1) ? 0 : (SITE_W + 1 - AW);

	localparam logic [AW-1:0]    LAST_SITE = AW'(SITE_COUNT - 1);
	localparam logic [AW-1:0]    SIDE_A    = AW'(LATTICE_SIDE);
	localparam logic [AW-1:0]    FAR_ROW   = AW'(SITE_COUNT - LATTICE_SIDE);
	localparam logic [ALU_W-1:0] K_ONE     = ALU_W'(1);
	localparam logic [ALU_W-1:0] K_LAST    = ALU_W'(SITE_COUNT - 1);
	localparam logic [ALU_W-1:0] K_SIDE    = ALU_W'(LATTICE_SIDE);
	localparam logic [ALU_W-1:0] K_FAR     = ALU_W'(SITE_COUNT - LATTICE_SIDE);
	localparam logic [ALU_W-1:0] K_COUNT   = ALU_W'(SITE_COUNT);
	localparam logic [ALU_W-1:0] K_TWO     = ALU_W'(2);

	// sequencer states
	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_MOD     = 4'd2;
	localparam logic [3:0] S_SELF    = 4'd3;
	localparam logic [3:0] S_NB_ADDR = 4'd4;
	localparam logic [3:0] S_NB_ACC  = 4'd5;
	localparam logic [3:0] S_SCALE   = 4'd6;
	localparam logic [3:0] S_DECIDE  = 4'd7;
	localparam logic [3:0] S_ENERGY  = 4'd8;
	localparam logic [3:0] S_MAGNET  = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	// neighbor order
	localparam logic [1:0] NB_RIGHT = 2'd0;
	localparam logic [1:0] NB_LEFT  = 2'd1;
	localparam logic [1:0] NB_DOWN  = 2'd2;
	localparam logic [1:0] NB_UP    = 2'd3;

	// configuration registers
	logic signed [COUPLING_W-1:0] j_q;
	logic signed [FIELD_W-1:0]    h_q;
	logic [TABLE_W-1:0]           plus_q;
	logic [TABLE_W-1:0]           minus_q;

	// sequencer and working registers
	logic [3:0]               state_q;
	logic [AW-1:0]            clr_q;
	logic [STEP_W-1:0]        k_q;
	logic [1:0]               nb_q;
	logic [RW-1:0]            r_q;
	logic                     type_q;
	logic                     want_q;
	logic [DRAW_W-1:0]        draw_q;
	logic                     s_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [PLUS_W-1:0]        plus_cnt_q;
	logic signed [DE_W-1:0]   de_q;
	logic                     flip_q;
	logic [ENERGY_W-1:0]      energy_q;
	logic [MAGNET_W-1:0]      magnet_q;

	// output register
	logic                       out_valid_q;
	logic                       out_flipped_q;
	logic                       out_spin_q;
	logic signed [DE_OUT_W-1:0] out_de_q;
	logic [ENERGY_W-1:0]        out_energy_q;
	logic [MAGNET_W-1:0]        out_magnet_q;

	alu_op_t          alu_op;
	logic [ALU_W-1:0] alu_res;
	logic             alu_neg;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_data;

	logic [AW-1:0]              site;
	logic [TABLE_W-1:0]         tab;
	logic [THR_W-1:0]           thr;
	logic                       de_le_zero;
	logic                       flip_now;
	logic signed [DE_OUT_W-1:0] de_sat;
	logic                       out_free;

	assign site = r_q[AW-1:0];

	imf_alu u_alu (
		.op  (alu_op),
		.res (alu_res),
		.neg (alu_neg)
	);

	imf_lattice #(
		.LATTICE_SIDE(LATTICE_SIDE)
	) u_lattice (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Threshold lookup: the entry index is the count of +1 neighbors,
	// which equals (sum + 4) / 2.
	always_comb begin
		tab = (s_q == SPIN_MINUS) ? minus_q : plus_q;
		thr = '0;
		for (int i = 0; i < THR_N; i++) begin
			if (plus_cnt_q == PLUS_W'(i)) begin
				thr = tab[i*THR_W +: THR_W];
			end
		end
	end

	assign de_le_zero = de_q[DE_W-1] || (de_q == '0);
	// set request: flip when the stored spin differs; otherwise Metropolis test
	assign flip_now = (type_q == REQ_SET) ? (s_q != want_q) : (de_le_zero || alu_neg);

	// clamp dE to the 8-bit result field
	always_comb begin
		if (de_q > DE_W'(127)) begin
			de_sat = DE_OUT_W'(127);
		end else if (de_q < -DE_W'(128)) begin
			de_sat = DE_OUT_W'(-128);
		end else begin
			de_sat = de_q[DE_OUT_W-1:0];
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	// Steer the shared adder and the spin memory for the current step.
	always_comb begin
		alu_op  = '0;
		rd_en   = 1'b0;
		rd_addr = site;
		wr_en   = 1'b0;
		wr_addr = site;
		wr_data = ~s_q;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = SPIN_PLUS;
			end
			S_MOD: begin
				// trial subtract of SITE_COUNT scaled by the current step
				alu_op.a   = ALU_W'(r_q);
				alu_op.b   = K_COUNT << k_q;
				alu_op.sub = 1'b1;
			end
			S_SELF: begin
				rd_en = 1'b1;
			end
			S_NB_ADDR: begin
				alu_op.a = ALU_W'(site);
				case (nb_q)
					NB_RIGHT: begin
						alu_op.b   = (site == LAST_SITE) ? K_LAST : K_ONE;
						alu_op.sub = (site == LAST_SITE);
					end
					NB_LEFT: begin
						alu_op.b   = (site == '0) ? K_LAST : K_ONE;
						alu_op.sub = (site != '0);
					end
					NB_DOWN: begin
						alu_op.b   = (site >= FAR_ROW) ? K_FAR : K_SIDE;
						alu_op.sub = (site >= FAR_ROW);
					end
					NB_UP: begin
						alu_op.b   = (site < SIDE_A) ? K_FAR : K_SIDE;
						alu_op.sub = (site >= SIDE_A);
					end
					default: begin
						alu_op.b   = '0;
						alu_op.sub = 1'b0;
					end
				endcase
				rd_en   = 1'b1;
				rd_addr = alu_res[AW-1:0];
			end
			S_NB_ACC: begin
				// add J for a +1 neighbor, subtract it for a -1 neighbor
				alu_op.a   = ALU_W'(acc_q);
				alu_op.b   = ALU_W'(j_q);
				alu_op.sub = rd_data;
			end
			S_SCALE: begin
				// negate the local field when the spin is -1
				alu_op.a   = '0;
				alu_op.b   = ALU_W'(acc_q);
				alu_op.sub = s_q;
			end
			S_DECIDE: begin
				alu_op.a   = ALU_W'(draw_q);
				alu_op.b   = ALU_W'(thr);
				alu_op.sub = 1'b1;
			end
			S_ENERGY: begin
				alu_op.a = ALU_W'(energy_q);
				alu_op.b = ALU_W'(de_q);
				wr_en    = 1'b1;
			end
			S_MAGNET: begin
				// a +1 spin turning to -1 lowers the magnetization by two
				alu_op.a   = ALU_W'(magnet_q);
				alu_op.b   = K_TWO;
				alu_op.sub = (s_q == SPIN_PLUS);
			end
			default: begin
				alu_op = '0;
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= COUPLING_W'(1);
			h_q     <= '0;
			plus_q  <= '0;
			minus_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUPLING_J:   j_q     <= cfg_data[COUPLING_W-1:0];
				CFG_FIELD_H:      h_q     <= cfg_data[FIELD_W-1:0];
				CFG_ACCEPT_PLUS:  plus_q  <= cfg_data[TABLE_W-1:0];
				CFG_ACCEPT_MINUS: minus_q <= cfg_data[TABLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			energy_q <= '0;
			magnet_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_SITE) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= (MOD_STEPS > 0) ? S_MOD : S_SELF;
					end
				end
				S_MOD: begin
					if (k_q == '0) begin
						state_q <= S_SELF;
					end
				end
				S_SELF: begin
					state_q <= S_NB_ADDR;
				end
				S_NB_ADDR: begin
					state_q <= S_NB_ACC;
				end
				S_NB_ACC: begin
					state_q <= (nb_q == NB_UP) ? S_SCALE : S_NB_ADDR;
				end
				S_SCALE: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= flip_now ? S_ENERGY : S_DONE;
				end
				S_ENERGY: begin
					energy_q <= alu_res[ENERGY_W-1:0];
					state_q  <= S_MAGNET;
				end
				S_MAGNET: begin
					magnet_q <= alu_res[MAGNET_W-1:0];
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				r_q    <= RW'(req.site_index);
				type_q <= req.req_type;
				want_q <= req.spin_value;
				draw_q <= req.random_draw;
				k_q    <= STEP_W'(MOD_STEPS - 1);
			end
			S_MOD: begin
				// keep the difference when it did not go negative
				if (!alu_neg) begin
					r_q <= alu_res[RW-1:0];
				end
				k_q <= k_q - STEP_W'(1);
			end
			S_SELF: begin
				acc_q      <= ACC_W'(h_q);
				plus_cnt_q <= '0;
				nb_q       <= NB_RIGHT;
			end
			S_NB_ADDR: begin
				// the addressed spin arrives ahead of the first neighbor
				if (nb_q == NB_RIGHT) begin
					s_q <= rd_data;
				end
			end
			S_NB_ACC: begin
				acc_q <= alu_res[ACC_W-1:0];
				if (rd_data == SPIN_PLUS) begin
					plus_cnt_q <= plus_cnt_q + PLUS_W'(1);
				end
				nb_q <= nb_q + 2'd1;
			end
			S_SCALE: begin
				de_q <= {alu_res[DE_W-2:0], 1'b0};
			end
			S_DECIDE: begin
				flip_q <= flip_now;
			end
			default: ;
		endcase
	end

	// Output register: valid handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_flipped_q <= flip_q;
			out_spin_q    <= s_q ^ flip_q;
			out_de_q      <= de_sat;
			out_energy_q  <= energy_q;
			out_magnet_q  <= magnet_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.flipped       = out_flipped_q;
	assign rsp.spin_now      = out_spin_q;
	assign rsp.energy_change = out_de_q;
	assign rsp.energy_total  = out_energy_q;
	assign rsp.magnetization = out_magnet_q;

endmodule
